@@ design/bpd_pkg.sv @@
// Shared types, codes and widths for the BMP pixel stream decoder.
`timescale 1ns / 1ps

package bpd_pkg;

  // Default sizing
  localparam int unsigned MAX_DIMENSION_DEF   = 4096;
  localparam int unsigned PALETTE_ENTRIES_DEF = 256;

  // Field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned CFG_DIM_W  = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // Bit offsets of the output tdata fields
  localparam int unsigned OUT_COL_LSB = 24;
  localparam int unsigned OUT_ROW_LSB = 36;

  // Bits per pixel codes
  typedef enum logic [2:0] {
    DEPTH_1  = 3'd0,
    DEPTH_4  = 3'd1,
    DEPTH_8  = 3'd2,
    DEPTH_16 = 3'd3,
    DEPTH_24 = 3'd4,
    DEPTH_32 = 3'd5
  } depth_e;

  // Input item kinds
  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_PIXEL   = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_e;

endpackage

@@ design/bpd_palette_ram.sv @@
// Palette memory: one write port, one registered read port.
`timescale 1ns / 1ps

module bpd_palette_ram
  import bpd_pkg::*;
#(
  parameter int unsigned ENTRIES = PALETTE_ENTRIES_DEF,
  parameter int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [COLOR_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [COLOR_W-1:0] rd_data_o
);

  logic [COLOR_W-1:0] mem [ENTRIES];
  logic [COLOR_W-1:0] rd_data_q;

  // Write entry; read returns the old contents on a same-cycle collision
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/bmp_pixel_stream_decoder_top.sv @@
// Top level of the BMP pixel stream decoder: byte unpacker, palette lookup, output stage.
`timescale 1ns / 1ps

// Decodes uncompressed BMP pixel-data bytes into blue/green/red pixels with
// their column and row (bottom row first). Input items are either palette
// writes (tuser = 0) or pixel data bytes (tuser = 1). A data byte gives as
// many pixels as it holds, fewer where its row ends inside it: eight at
// 1 bpp, two at 4 bpp, one at 8 bpp, and one on the completing byte of a 16,
// 24 or 32 bpp pixel. The unpacker issues one pixel per cycle while the
// output register is not stalled. Each palette pixel does one read of the
// single palette read port, loaded at the same edge as the output register;
// the first result of a byte passes through the unpacker register and then
// the output register. The next item is taken in the cycle in which the
// current byte issues its last pixel, while the output register may still
// hold an untaken result. Row padding bytes are consumed without a result,
// and bytes after the final pixel are dropped until a configuration write
// restarts the image. The palette is not cleared by reset; configuration
// writes keep it and restart the image; they are taken only when no byte is
// in the unpacker.
module bmp_pixel_stream_decoder_top
  import bpd_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION   = MAX_DIMENSION_DEF,
  parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] palette_index, [15:8] entry_blue, [23:16] entry_green,
  // [31:24] entry_red, [39:32] data_byte
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] opcode
  input  logic                  s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] blue, [15:8] green, [23:16] red, [35:24] column, [47:36] row
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] run_last
  output logic                  m_axis_tlast,
  // [0] image_done
  output logic                  m_axis_tuser
);

  localparam int unsigned DW  = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CLW = (DW > CFG_DIM_W) ? DW : CFG_DIM_W;
  localparam int unsigned AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // Clamp a configured dimension to the range one to MAX_DIMENSION
  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [CLW-1:0] ve;
    ve = CLW'(v);
    if (ve == '0) begin
      return DW'(1);
    end else if (ve > CLW'(MAX_DIMENSION)) begin
      return DW'(MAX_DIMENSION);
    end else begin
      return DW'(ve);
    end
  endfunction

  // Configuration registers
  depth_e               depth_q;
  logic [CFG_DIM_W-1:0] width_q, height_q;

  // Image position state
  logic [COLOR_W-1:0] partial_q, partial_d;
  logic [1:0]         phase_q, phase_d;
  logic [DW-1:0]      col_q, col_d;
  logic [DW-1:0]      row_q, row_d;
  logic [1:0]         rbc_q, rbc_d;
  logic               pad_q, pad_d;
  logic               fin_q, fin_d;

  // Unpacker register: the byte being issued and its pixel index
  logic              u_valid_q;
  logic [BYTE_W-1:0] u_byte_q;
  logic [2:0]        u_k_q;

  // Output stage
  logic               v2_q;
  logic               pal2_q;
  logic [COLOR_W-1:0] bgr2_q;
  logic [POS_W-1:0]   col2_q, row2_q;
  logic               last2_q, done2_q;

  // Issue signals
  logic               out_adv, issue_go, u_done;
  logic               in_acc, cfg_acc, cfg_hit;
  logic               first, depth_ok;
  logic               pix_valid, pix_pal, byte_last, img_done, row_end;
  logic [BYTE_W-1:0]  pix_idx;
  logic [COLOR_W-1:0] pix_bgr, partial_n;
  logic [1:0]         rbc_cur;
  logic [DW-1:0]      col_inc, w_eff;
  logic [15:0]        word16;
  logic               idx_in_range;
  logic [COLOR_W-1:0] pal_rdata;
  logic [CFG_DIM_W-1:0] height_new;

  // Handshakes
  assign out_adv       = !v2_q || m_axis_tready;
  assign issue_go      = u_valid_q && out_adv;
  assign u_done        = issue_go && byte_last;
  assign s_axis_tready = !u_valid_q || u_done;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = !u_valid_q;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign cfg_hit       = (cfg_index_i == REG_DEPTH) || (cfg_index_i == REG_WIDTH) ||
                         (cfg_index_i == REG_HEIGHT);
  assign height_new    = (cfg_index_i == REG_HEIGHT) ? cfg_data_i : height_q;

  // Position arithmetic for the pixel issued this cycle
  assign w_eff        = clamp_dim(width_q);
  assign col_inc      = col_q + DW'(1);
  assign row_end      = col_inc >= w_eff;
  assign img_done     = row_end && (row_q == '0);
  assign first        = (u_k_q == 3'd0);
  assign depth_ok     = (depth_q <= DEPTH_32);
  assign rbc_cur      = first ? (rbc_q + 2'd1) : rbc_q;
  assign word16       = {u_byte_q, partial_q[BYTE_W-1:0]};
  assign idx_in_range = {1'b0, pix_idx} < 9'(PALETTE_ENTRIES);

  // Decode the current byte: pixel issue and next image state
  always_comb begin
    partial_d = partial_q;
    phase_d   = phase_q;
    col_d     = col_q;
    row_d     = row_q;
    rbc_d     = rbc_q;
    pad_d     = pad_q;
    fin_d     = fin_q;
    pix_valid = 1'b0;
    pix_pal   = 1'b0;
    pix_idx   = u_byte_q;
    pix_bgr   = '0;
    byte_last = 1'b1;
    partial_n = partial_q;
    if (first && (fin_q || !depth_ok)) begin
      // drop bytes after the image or in an unused mode
      byte_last = 1'b1;
    end else begin
      rbc_d = rbc_cur;
      if (first && pad_q) begin
        // consume row padding, move to next row at the word boundary
        if (rbc_cur == 2'd0) begin
          pad_d = 1'b0;
          col_d = '0;
          row_d = row_q - DW'(1);
        end
      end else begin
        case (depth_q)
          DEPTH_1: begin
            pix_valid = 1'b1;
            pix_pal   = 1'b1;
            pix_idx   = BYTE_W'(u_byte_q[3'd7 - u_k_q]);
            byte_last = (u_k_q == 3'd7) || row_end;
          end
          DEPTH_4: begin
            pix_valid = 1'b1;
            pix_pal   = 1'b1;
            pix_idx   = BYTE_W'(u_k_q[0] ? u_byte_q[3:0] : u_byte_q[7:4]);
            byte_last = u_k_q[0] || row_end;
          end
          DEPTH_8: begin
            pix_valid = 1'b1;
            pix_pal   = 1'b1;
          end
          DEPTH_16: begin
            if (phase_q == 2'd0) begin
              partial_d = COLOR_W'(u_byte_q);
              phase_d   = 2'd1;
            end else begin
              pix_valid = 1'b1;
              pix_bgr   = {word16[14:10], 3'b000, word16[9:5], 3'b000,
                           word16[4:0], 3'b000};
              phase_d   = 2'd0;
              partial_d = '0;
            end
          end
          DEPTH_24, DEPTH_32: begin
            case (phase_q)
              2'd0:    partial_n[7:0]   = u_byte_q;
              2'd1:    partial_n[15:8]  = u_byte_q;
              2'd2:    partial_n[23:16] = u_byte_q;
              default: partial_n = partial_q;
            endcase
            if (phase_q >= ((depth_q == DEPTH_24) ? 2'd2 : 2'd3)) begin
              pix_valid = 1'b1;
              pix_bgr   = partial_n;
              phase_d   = 2'd0;
              partial_d = '0;
            end else begin
              phase_d   = phase_q + 2'd1;
              partial_d = partial_n;
            end
          end
          default: begin
            byte_last = 1'b1;
          end
        endcase
        // advance position for an issued pixel
        if (pix_valid) begin
          col_d = col_inc;
          if (row_end) begin
            if (img_done) begin
              fin_d = 1'b1;
            end else if (rbc_cur == 2'd0) begin
              col_d = '0;
              row_d = row_q - DW'(1);
            end else begin
              pad_d = 1'b1;
            end
          end
        end
      end
    end
  end

  // Configuration registers and image state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= DEPTH_24;
      width_q   <= CFG_DIM_W'(1);
      height_q  <= CFG_DIM_W'(1);
      partial_q <= '0;
      phase_q   <= '0;
      col_q     <= '0;
      row_q     <= '0;
      rbc_q     <= '0;
      pad_q     <= 1'b0;
      fin_q     <= 1'b0;
    end else if (cfg_acc && cfg_hit) begin
      case (cfg_index_i)
        REG_DEPTH:  depth_q  <= depth_e'(cfg_data_i[2:0]);
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
      // restart the image
      partial_q <= '0;
      phase_q   <= '0;
      col_q     <= '0;
      row_q     <= clamp_dim(height_new) - DW'(1);
      rbc_q     <= '0;
      pad_q     <= 1'b0;
      fin_q     <= 1'b0;
    end else if (issue_go) begin
      partial_q <= partial_d;
      phase_q   <= phase_d;
      col_q     <= col_d;
      row_q     <= row_d;
      rbc_q     <= rbc_d;
      pad_q     <= pad_d;
      fin_q     <= fin_d;
    end
  end

  // Unpacker register: load a data byte, step through its pixels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_valid_q <= 1'b0;
      u_k_q     <= '0;
    end else if (in_acc && (s_axis_tuser == OP_PIXEL)) begin
      u_valid_q <= 1'b1;
      u_k_q     <= '0;
    end else if (u_done) begin
      u_valid_q <= 1'b0;
    end else if (issue_go) begin
      u_k_q <= u_k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (s_axis_tuser == OP_PIXEL)) begin
      u_byte_q <= s_axis_tdata[39:32];
    end
  end

  // Palette lookup
  bpd_palette_ram #(
    .ENTRIES (PALETTE_ENTRIES),
    .AW      (AW)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && (s_axis_tuser == OP_PALETTE) &&
                ({1'b0, s_axis_tdata[7:0]} < 9'(PALETTE_ENTRIES))),
    .wr_addr_i (AW'(s_axis_tdata[7:0])),
    .wr_data_i (s_axis_tdata[31:8]),
    .rd_en_i   (issue_go && pix_valid && pix_pal && idx_in_range),
    .rd_addr_i (AW'(pix_idx)),
    .rd_data_o (pal_rdata)
  );

  // Output stage: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (out_adv) begin
      v2_q <= issue_go && pix_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_go) begin
      pal2_q  <= pix_pal && idx_in_range;
      bgr2_q  <= pix_bgr;
      col2_q  <= POS_W'(col_q);
      row2_q  <= POS_W'(row_q);
      last2_q <= byte_last;
      done2_q <= img_done;
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {row2_q, col2_q, pal2_q ? pal_rdata : bgr2_q};
  assign m_axis_tlast  = last2_q;
  assign m_axis_tuser  = done2_q;

endmodule

@@ design/bpd_checker.sv @@
// Port-level checker for the BMP pixel stream decoder, bound to the top level.
`timescale 1ns / 1ps

module bpd_checker
  import bpd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic                  m_axis_tuser
);

  // Final pixel always closes the run of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("image_done without run_last");

  // Final pixel lies in row zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[OUT_DATA_W-1:OUT_ROW_LSB] == '0))
    else $error("image_done outside row zero");

  // Stalled result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("stalled output changed");

endmodule

bind bmp_pixel_stream_decoder_top bpd_checker u_bpd_checker (.*);

@@ bench/tb_bmp_pixel_stream_decoder_top.sv @@
// Self-checking testbench for the BMP pixel stream decoder top level.
`timescale 1ns / 1ps

module tb_bmp_pixel_stream_decoder_top;
  import bpd_pkg::*;

  // Depth codes the block has no mode for
  localparam logic [2:0] DEPTH_UNUSED_LO = 3'd6;
  localparam logic [2:0] DEPTH_UNUSED_HI = 3'd7;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned RANDOM_ITEMS   = 300;

  typedef struct packed {
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             run_last;
    logic             image_done;
  } pixel_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = REG_DEPTH;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = OP_PALETTE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  bmp_pixel_stream_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Decoder shadow state
  logic [2:0]   depth_reg;
  int unsigned  width_reg;
  int unsigned  height_reg;
  logic [23:0]  palette_mem [PALETTE_ENTRIES_DEF];
  bit           palette_written [PALETTE_ENTRIES_DEF];
  int unsigned  written_entries [$];
  logic [23:0]  partial_bgr;
  int unsigned  byte_slot;
  int           col_count;
  int           row_count;
  int unsigned  row_byte_idx;
  bit           padding;
  bit           image_finished;

  pixel_t       expected_pixels [$];
  pixel_t       got_px;
  pixel_t       exp_px;
  int unsigned  mismatch_count = 0;
  bit           item_took;
  bit           gap_on = 1'b1;
  bit           stall_on = 1'b1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready <= !(stall_on && $urandom_range(0, 99) < 33);
  end

  function automatic int unsigned clamp_dim(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
    return v;
  endfunction

  function automatic void restart_image();
    partial_bgr    = '0;
    byte_slot      = 0;
    col_count      = 0;
    row_count      = clamp_dim(height_reg) - 1;
    row_byte_idx   = 0;
    padding        = 1'b0;
    image_finished = 1'b0;
  endfunction

  // Queue one pixel and advance the position; returns 1 at the end of a row
  function automatic bit push_pixel(input logic [23:0] bgr);
    pixel_t px;
    bit     row_end;
    bit     last_px;
    col_count++;
    row_end       = col_count >= clamp_dim(width_reg);
    last_px       = row_end && row_count == 0;
    px.blue       = bgr[7:0];
    px.green      = bgr[15:8];
    px.red        = bgr[23:16];
    px.column     = POS_W'(col_count - 1);
    px.row        = POS_W'(row_count);
    px.run_last   = 1'b0;
    px.image_done = last_px;
    expected_pixels.push_back(px);
    if (row_end) begin
      if (last_px) begin
        image_finished = 1'b1;
      end else if (row_byte_idx == 0) begin
        col_count = 0;
        row_count--;
      end else begin
        padding = 1'b1;
      end
    end
    return row_end;
  endfunction

  // Work out the pixels of one accepted item; returns 0 if the block drops it
  function automatic bit decode_item(input logic op, input logic [IN_DATA_W-1:0] data);
    logic [7:0]  b;
    logic [7:0]  idx;
    logic [15:0] word;
    logic [23:0] bgr;
    int unsigned bits;
    int unsigned count;
    int unsigned last_slot;
    int unsigned k;
    int          start;
    b = data[39:32];
    if (op == OP_PALETTE) begin
      palette_mem[data[7:0]] = data[31:8];
      if (!palette_written[data[7:0]]) written_entries.push_back(data[7:0]);
      palette_written[data[7:0]] = 1'b1;
      return 1'b1;
    end
    if (image_finished || depth_reg > DEPTH_32) return 1'b0;
    row_byte_idx = (row_byte_idx + 1) & 3;
    if (padding) begin
      if (row_byte_idx == 0) begin
        padding   = 1'b0;
        col_count = 0;
        row_count--;
      end
      return 1'b1;
    end
    start = expected_pixels.size();
    case (depth_reg)
      DEPTH_1, DEPTH_4: begin
        bits  = (depth_reg == DEPTH_1) ? 1 : 4;
        count = 8 / bits;
        for (k = 0; k < count; k++) begin
          idx = 8'((b >> (8 - bits * (k + 1))) & ((1 << bits) - 1));
          if (push_pixel(palette_mem[idx])) break;
        end
      end
      DEPTH_8: begin
        void'(push_pixel(palette_mem[b]));
      end
      DEPTH_16: begin
        if (byte_slot == 0) begin
          partial_bgr = {16'h0, b};
          byte_slot   = 1;
        end else begin
          word        = {b, partial_bgr[7:0]};
          bgr         = {word[14:10], 3'b000, word[9:5], 3'b000, word[4:0], 3'b000};
          byte_slot   = 0;
          partial_bgr = '0;
          void'(push_pixel(bgr));
        end
      end
      default: begin
        last_slot = (depth_reg == DEPTH_24) ? 2 : 3;
        if (byte_slot < 3) partial_bgr = partial_bgr | (24'(b) << (8 * byte_slot));
        if (byte_slot >= last_slot) begin
          bgr         = partial_bgr;
          byte_slot   = 0;
          partial_bgr = '0;
          void'(push_pixel(bgr));
        end else begin
          byte_slot = (byte_slot + 1) & 3;
        end
      end
    endcase
    if (expected_pixels.size() > start) begin
      expected_pixels[expected_pixels.size() - 1].run_last = 1'b1;
    end
    return 1'b1;
  endfunction

  // True if this data byte would look up a palette entry never written
  function automatic bit reads_unwritten(input logic [7:0] b);
    int unsigned bits;
    int          count;
    int          k;
    logic [7:0]  idx;
    if (image_finished || padding || depth_reg > DEPTH_8) return 1'b0;
    bits  = (depth_reg == DEPTH_1) ? 1 : (depth_reg == DEPTH_4) ? 4 : 8;
    count = 8 / bits;
    if (clamp_dim(width_reg) - col_count < count) count = clamp_dim(width_reg) - col_count;
    for (k = 0; k < count; k++) begin
      idx = 8'((b >> (8 - bits * (k + 1))) & ((1 << bits) - 1));
      if (!palette_written[idx]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Check each pixel transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got_px.blue       = m_axis_tdata[7:0];
      got_px.green      = m_axis_tdata[15:8];
      got_px.red        = m_axis_tdata[23:16];
      got_px.column     = m_axis_tdata[OUT_COL_LSB +: POS_W];
      got_px.row        = m_axis_tdata[OUT_ROW_LSB +: POS_W];
      got_px.run_last   = m_axis_tlast;
      got_px.image_done = m_axis_tuser;
      if (expected_pixels.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected pixel b=%02h g=%02h r=%02h col=%0d row=%0d last=%0b done=%0b",
                   got_px.blue, got_px.green, got_px.red, got_px.column, got_px.row,
                   got_px.run_last, got_px.image_done);
        end
        mismatch_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (got_px.blue !== exp_px.blue || got_px.green !== exp_px.green ||
            got_px.red !== exp_px.red || got_px.column !== exp_px.column ||
            got_px.row !== exp_px.row || got_px.run_last !== exp_px.run_last ||
            got_px.image_done !== exp_px.image_done) begin
          if (mismatch_count < 10) begin
            $display("pixel mismatch: exp b=%02h g=%02h r=%02h col=%0d row=%0d last=%0b done=%0b",
                     exp_px.blue, exp_px.green, exp_px.red, exp_px.column, exp_px.row,
                     exp_px.run_last, exp_px.image_done);
            $display("                got b=%02h g=%02h r=%02h col=%0d row=%0d last=%0b done=%0b",
                     got_px.blue, got_px.green, got_px.red, got_px.column, got_px.row,
                     got_px.run_last, got_px.image_done);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Send one input transfer, with a random gap ahead of it
  task automatic send_item(input logic op, input logic [IN_DATA_W-1:0] data);
    @(negedge clk_i);
    if (gap_on && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while (gap_on && $urandom_range(0, 99) < 33);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    item_took = decode_item(op, data);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_PIXEL, {b, 32'($urandom())});
  endtask

  task automatic write_palette(input logic [7:0] idx, input logic [23:0] bgr);
    send_item(OP_PALETTE, {8'($urandom()), bgr, idx});
  endtask

  // Hold the input side until every pixel is out, then let the block settle
  task automatic drain_pixels();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e reg_idx, input int unsigned value);
    drain_pixels();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= reg_idx;
    cfg_data_i  <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (reg_idx)
      REG_DEPTH:  depth_reg  = value[2:0];
      REG_WIDTH:  width_reg  = value[CFG_DATA_W-1:0];
      REG_HEIGHT: height_reg = value[CFG_DATA_W-1:0];
      default: ;
    endcase
    restart_image();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_image(input logic [2:0] depth, input int unsigned w, input int unsigned h);
    write_register(REG_DEPTH, depth);
    write_register(REG_WIDTH, w);
    write_register(REG_HEIGHT, h);
  endtask

  // 24 bpp single pixel after reset, then a byte past the end
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h5A);
  endtask

  // 1, 4 and 8 bpp with row padding and an early row end inside a byte
  task automatic test_palette_depths();
    write_palette(8'd0, 24'h000000);
    write_palette(8'd1, 24'hFFFFFF);
    write_palette(8'd255, 24'h5AA5C3);
    set_image(DEPTH_1, 3, 2);
    send_byte(8'hA0);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'hDF);
    set_image(DEPTH_4, 2, 1);
    send_byte(8'h10);
    set_image(DEPTH_8, 1, 1);
    send_byte(8'hFF);
  endtask

  // 16 bpp 5-5-5 across two rows, then a 32 bpp pixel with its dropped byte
  task automatic test_wide_depths();
    set_image(DEPTH_16, 1, 2);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h1F);
    send_byte(8'h7C);
    set_image(DEPTH_32, 1, 1);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h78);
  endtask

  // Drop data bytes under depth codes without a mode
  task automatic test_unused_depths();
    write_register(REG_DEPTH, DEPTH_UNUSED_LO);
    send_byte(8'hFF);
    send_byte(8'h00);
    write_register(REG_DEPTH, DEPTH_UNUSED_HI);
    send_byte(8'hA5);
  endtask

  // Largest and zero dimensions, clamped by the block
  task automatic test_dimension_extremes();
    int k;
    set_image(DEPTH_32, 8191, 8191);
    for (k = 0; k < 8; k++) send_byte(8'($urandom()));
    set_image(DEPTH_1, MAX_DIMENSION_DEF, MAX_DIMENSION_DEF);
    for (k = 0; k < 3; k++) send_byte(8'($urandom()));
    set_image(DEPTH_24, 0, 0);
    for (k = 0; k < 4; k++) send_byte(8'($urandom()));
  endtask

  // Random images: mostly well-formed byte runs, cut short by new settings at times
  task automatic test_random_images();
    int unsigned useful;
    int unsigned phase_idx;
    int unsigned budget;
    int unsigned pal_rate;
    int unsigned r;
    int unsigned n;
    int unsigned tries;
    int unsigned i;
    logic [2:0]  depth;
    int unsigned w;
    int unsigned h;
    logic [7:0]  b;
    useful    = 0;
    phase_idx = 0;
    while (useful < RANDOM_ITEMS) begin
      r = $urandom_range(0, 15);
      if (r == 15) depth = $urandom_range(0, 1) ? DEPTH_UNUSED_LO : DEPTH_UNUSED_HI;
      else depth = 3'(r % 6);
      r = $urandom_range(0, 9);
      if (r < 7) w = $urandom_range(1, 12);
      else if (r == 7) w = 0;
      else w = $urandom_range(13, 64);
      h = $urandom_range(0, 4);
      gap_on   = phase_idx != 0 && $urandom_range(0, 3) != 0;
      stall_on = phase_idx != 0 && $urandom_range(0, 3) != 0;
      set_image(depth, w, h);
      if (depth <= DEPTH_8) begin
        for (i = 0; i < 16; i++) begin
          if (!palette_written[i]) write_palette(8'(i), 24'($urandom()));
        end
      end
      budget   = (depth > DEPTH_32) ? 3 : (phase_idx == 0) ? 60 : $urandom_range(10, 60);
      pal_rate = (depth <= DEPTH_8) ? 15 : 5;
      for (n = 0; n < budget && !image_finished; n++) begin
        if (phase_idx == 2 && n == budget / 2) drain_pixels();
        if ($urandom_range(0, 99) < pal_rate) begin
          write_palette(8'($urandom()), 24'($urandom()));
        end else begin
          b     = 8'($urandom());
          tries = 0;
          while (reads_unwritten(b)) begin
            if (tries < 8) b = 8'($urandom());
            else b = 8'(written_entries[$urandom_range(0, written_entries.size() - 1)]);
            tries++;
          end
          send_byte(b);
        end
        if (item_took) useful++;
      end
      // Trailing bytes past the final pixel
      if (image_finished && $urandom_range(0, 1) != 0) send_byte(8'($urandom()));
      phase_idx++;
    end
  endtask

  initial begin
    depth_reg  = DEPTH_24;
    width_reg  = 1;
    height_reg = 1;
    restart_image();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_palette_depths();
    test_wide_depths();
    test_unused_depths();
    test_dimension_extremes();
    test_random_images();

    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_bmp_pixel_stream_decoder_top OK");
    end else begin
      $display("tb_bmp_pixel_stream_decoder_top NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #1_000_000;
    $display("tb_bmp_pixel_stream_decoder_top NOT OK");
    $finish;
  end

endmodule
